FILE: rtl/srafr_pkg.sv
// Shared types and protocol constants for the serial register access framer.
`timescale 1ns / 1ps

package srafr_pkg;

  localparam int BUFFER_DEPTH_DEF = 4096;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_TX,
    PH_WAIT_ACK,
    PH_NAK_EAT,
    PH_SKIP_HDR,
    PH_READ,
    PH_SKIP_ECHO
  } phase_t;

  // input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_RECV  = 2'd2;
  localparam logic [1:0] MODE_SLOT  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_IR_DATA  = 2'd0;
  localparam logic [1:0] CFG_EE_BASE  = 2'd1;
  localparam logic [1:0] CFG_EE_SIZE  = 2'd2;

  // frame and reply codes
  localparam logic [7:0] START_CODE = 8'h02;
  localparam logic [7:0] FN_LONG    = 8'h90;
  localparam logic [7:0] FN_SHORT   = 8'h80;
  localparam logic [7:0] FN_WRITE   = 8'h40;
  localparam logic [7:0] CODE_NAK   = 8'h15;
  localparam logic [7:0] CODE_ACK   = 8'h06;

endpackage

FILE: rtl/serial_register_access_framer_core.sv
// Top level of the serial register access framer: framing, reply tracking, write buffer.
//
// Input channel (in_valid / in_stall): one beat per command, write-data load,
// received link byte or free transmit slot, selected by mode.
// Output channel (out_valid / out_stall): transmit bytes, read data bytes
// (is_last on the final one) and transfer-complete beats with done_length.
// Config channel (cfg_valid / cfg_ready, always ready): IR data register,
// EEPROM window base and size; user writes only while the block is idle, unenforced.
//
// Throughput: one input beat per cycle while in_stall is low. A result passes
// through the result stage into the output register; the result stage waits for the
// registered read of the write buffer RAM that supplies frame data bytes.
// One result stage plus the output register sit between the two sides, so
// in_stall rises only when both are full and the receiver stalls.
// Reset (rst, synchronous) returns the framer to idle and empties the
// pipeline; the write buffer contents are not cleared and need no sweep.
`timescale 1ns / 1ps

module serial_register_access_framer_core #(
  parameter int BUFFER_DEPTH = srafr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        is_write,
  input  logic [11:0] length,
  input  logic [15:0] reg_addr,
  input  logic [7:0]  data_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        is_last,
  output logic [11:0] done_length,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import srafr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [12:0] DEPTH_C = 13'(BUFFER_DEPTH);

  // configuration
  logic [15:0] ir_data_register;
  logic [15:0] eeprom_window_base;
  logic [15:0] eeprom_window_size;

  // transfer state
  phase_t      phase, phase_next;
  logic        write_dir, write_dir_next;
  logic [11:0] xfer_length, xfer_length_next;
  logic [15:0] target_reg, target_reg_next;
  logic [12:0] frame_position, frame_position_next;
  logic [12:0] byte_counter, byte_counter_next;

  // result stage and buffer RAM
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic [11:0] s1_dl;
  logic        s1_mem;
  logic        s1_move;
  logic [7:0]  ram_rd_data;

  logic        acc;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [11:0] res_dl;
  logic        res_mem;
  logic        ram_we;
  logic        ram_re;

  logic        hlen5;
  logic [2:0]  hlen;
  logic [12:0] total;
  logic [12:0] fp_plus1;
  logic [12:0] data_idx;
  logic        in_data;
  logic        past_depth;
  logic [7:0]  fn_dir;
  logic [7:0]  hdr_byte;
  logic        load_ok;
  logic        exempt;
  logic        bc_more;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_data_register   <= '0;
      eeprom_window_base <= '0;
      eeprom_window_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IR_DATA: ir_data_register   <= cfg_data;
        CFG_EE_BASE: eeprom_window_base <= cfg_data;
        CFG_EE_SIZE: eeprom_window_size <= cfg_data;
        default:     ;
      endcase
    end
  end

  // frame geometry
  assign hlen5    = |xfer_length[11:4];
  assign hlen     = hlen5 ? 3'd5 : 3'd4;
  assign total    = {10'b0, hlen} + (write_dir ? {1'b0, xfer_length} : 13'd0);
  assign fp_plus1 = frame_position + 13'd1;
  assign data_idx = frame_position - {10'b0, hlen};
  assign in_data  = frame_position >= {10'b0, hlen};
  assign past_depth = data_idx >= DEPTH_C;
  assign fn_dir   = write_dir ? FN_WRITE : 8'h00;

  always_comb begin
    hdr_byte = 8'h00;
    if (frame_position == 13'd0) begin
      hdr_byte = START_CODE;
    end else if (hlen5) begin
      if (frame_position == 13'd1) hdr_byte = FN_LONG | fn_dir | {4'b0, xfer_length[11:8]};
      else if (frame_position == 13'd2) hdr_byte = xfer_length[7:0];
      else if (frame_position == 13'd3) hdr_byte = target_reg[15:8];
      else if (frame_position == 13'd4) hdr_byte = target_reg[7:0];
    end else begin
      if (frame_position == 13'd1) hdr_byte = FN_SHORT | fn_dir | {4'b0, xfer_length[3:0]};
      else if (frame_position == 13'd2) hdr_byte = target_reg[15:8];
      else if (frame_position == 13'd3) hdr_byte = target_reg[7:0];
    end
  end

  // writes to the IR data register or into the EEPROM window return no echo
  assign exempt = (target_reg == ir_data_register) ||
                  ({1'b0, target_reg} >= {1'b0, eeprom_window_base} &&
                   {1'b0, target_reg} <= {1'b0, eeprom_window_base} +
                                         {1'b0, eeprom_window_size});

  assign load_ok = (phase == PH_IDLE || phase == PH_TX || phase == PH_WAIT_ACK ||
                    phase == PH_NAK_EAT) && (byte_counter < DEPTH_C);
  assign bc_more = byte_counter > 13'd1;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign acc      = in_valid && !in_stall;

  // next state
  always_comb begin
    phase_next          = phase;
    write_dir_next      = write_dir;
    xfer_length_next    = xfer_length;
    target_reg_next     = target_reg;
    frame_position_next = frame_position;
    byte_counter_next   = byte_counter;
    if (acc) begin
      unique case (mode)
        MODE_START: begin
          if (phase == PH_IDLE) begin
            write_dir_next      = is_write;
            xfer_length_next    = length;
            target_reg_next     = reg_addr;
            frame_position_next = '0;
            phase_next          = PH_TX;
          end
        end
        MODE_LOAD: begin
          if (load_ok) byte_counter_next = byte_counter + 13'd1;
        end
        MODE_SLOT: begin
          if (phase == PH_TX) begin
            frame_position_next = fp_plus1;
            if (fp_plus1 >= total) phase_next = PH_WAIT_ACK;
          end
        end
        MODE_RECV: begin
          unique case (phase)
            PH_WAIT_ACK: begin
              if (data_byte == CODE_NAK) begin
                phase_next = PH_NAK_EAT;
              end else if (data_byte == CODE_ACK) begin
                byte_counter_next = {10'b0, hlen} - 13'd1;
                phase_next        = PH_SKIP_HDR;
              end else begin
                frame_position_next = '0;
                phase_next          = PH_TX;
              end
            end
            PH_NAK_EAT: begin
              frame_position_next = '0;
              phase_next          = PH_TX;
            end
            PH_SKIP_HDR: begin
              if (bc_more) begin
                byte_counter_next = byte_counter - 13'd1;
              end else if (xfer_length == 12'd0 || (write_dir && exempt)) begin
                byte_counter_next = '0;
                phase_next        = PH_IDLE;
              end else begin
                byte_counter_next = {1'b0, xfer_length};
                phase_next        = write_dir ? PH_SKIP_ECHO : PH_READ;
              end
            end
            PH_READ, PH_SKIP_ECHO: begin
              if (bc_more) begin
                byte_counter_next = byte_counter - 13'd1;
              end else begin
                byte_counter_next = '0;
                phase_next        = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // results and buffer access
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_TX;
    res_byte  = 8'h00;
    res_last  = 1'b0;
    res_dl    = '0;
    res_mem   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    if (acc) begin
      unique case (mode)
        MODE_LOAD: ram_we = load_ok;
        MODE_SLOT: begin
          if (phase == PH_TX) begin
            res_valid = 1'b1;
            res_byte  = hdr_byte;
            res_mem   = in_data && !past_depth;
            ram_re    = in_data && !past_depth;
          end
        end
        MODE_RECV: begin
          unique case (phase)
            PH_SKIP_HDR: begin
              if (!bc_more && (xfer_length == 12'd0 || (write_dir && exempt))) begin
                res_valid = 1'b1;
                res_kind  = KIND_DONE;
                res_dl    = xfer_length;
              end
            end
            PH_READ: begin
              res_valid = 1'b1;
              res_kind  = KIND_READ;
              res_byte  = data_byte;
              res_last  = !bc_more;
              res_dl    = bc_more ? 12'd0 : xfer_length;
            end
            PH_SKIP_ECHO: begin
              if (!bc_more) begin
                res_valid = 1'b1;
                res_kind  = KIND_DONE;
                res_dl    = xfer_length;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      write_dir      <= 1'b0;
      xfer_length    <= '0;
      target_reg     <= '0;
      frame_position <= '0;
      byte_counter   <= '0;
    end else begin
      phase          <= phase_next;
      write_dir      <= write_dir_next;
      xfer_length    <= xfer_length_next;
      target_reg     <= target_reg_next;
      frame_position <= frame_position_next;
      byte_counter   <= byte_counter_next;
    end
  end

  srafr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_wbuf (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (byte_counter[AW-1:0]),
    .wr_data (data_byte),
    .rd_en   (ram_re),
    .rd_addr (data_idx[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // result stage: holds the result while the registered buffer read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc && res_valid) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      s1_kind <= res_kind;
      s1_byte <= res_byte;
      s1_last <= res_last;
      s1_dl   <= res_dl;
      s1_mem  <= res_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_kind    <= s1_kind;
      out_byte    <= s1_mem ? ram_rd_data : s1_byte;
      is_last     <= s1_last;
      done_length <= s1_dl;
    end
  end

  // buffer read data must hold while a frame byte waits in the result stage
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> $stable(ram_rd_data))
    else $error("buffer read data changed under a held result");

  a_last_is_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_last |-> out_kind == KIND_READ)
    else $error("last marker on a non-read beat");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    acc && res_valid && res_kind == KIND_DONE |=> phase == PH_IDLE && byte_counter == 13'd0)
    else $error("completion did not return to idle");

  a_fp_in_frame: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TX |-> frame_position < total)
    else $error("frame position beyond frame");

endmodule

FILE: rtl/srafr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module srafr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: verif/framer_tracker_pkg.sv
// Predictor and scoreboard of the framer's output beats.
`timescale 1ns / 1ps

package framer_tracker_pkg;
  import srafr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [11:0] dlen;
  } link_out_t;

  class framer_tracker;
    logic [15:0] ir_reg;
    logic [15:0] win_base;
    logic [15:0] win_size;

    phase_t      ph;
    logic        dir;
    logic [11:0] xlen;
    logic [15:0] treg;
    int unsigned fpos;
    int unsigned bcnt;
    logic [7:0]  wbuf [BUFFER_DEPTH_DEF];

    link_out_t   owed[$];
    int unsigned errors;
    int unsigned n_tx;
    int unsigned n_rd;
    int unsigned n_done;
    int unsigned n_nak;
    int unsigned n_junk;
    int unsigned n_exempt;

    function new();
      ir_reg = '0;
      win_base = '0;
      win_size = '0;
      ph = PH_IDLE;
      dir = 1'b0;
      xlen = '0;
      treg = '0;
      fpos = 0;
      bcnt = 0;
      errors = 0;
      n_tx = 0;
      n_rd = 0;
      n_done = 0;
      n_nak = 0;
      n_junk = 0;
      n_exempt = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        CFG_IR_DATA: ir_reg = v;
        CFG_EE_BASE: win_base = v;
        CFG_EE_SIZE: win_size = v;
        default: ;
      endcase
    endfunction

    function int unsigned hdr_bytes();
      return (xlen > 12'd15) ? 5 : 4;
    endfunction

    function logic [7:0] frame_at(int unsigned pos);
      logic [7:0]  fn;
      int unsigned h;
      fn = dir ? FN_WRITE : '0;
      h = hdr_bytes();
      if (pos == 0) return START_CODE;
      if (h == 5) begin
        if (pos == 1) return FN_LONG | fn | {4'h0, xlen[11:8]};
        if (pos == 2) return xlen[7:0];
        if (pos == 3) return treg[15:8];
        if (pos == 4) return treg[7:0];
      end else begin
        if (pos == 1) return FN_SHORT | fn | {4'h0, xlen[3:0]};
        if (pos == 2) return treg[15:8];
        if (pos == 3) return treg[7:0];
      end
      if (pos - h < BUFFER_DEPTH_DEF) return wbuf[pos - h];
      return '0;
    endfunction

    // window end is computed one bit wider, so it never wraps to low addresses
    function bit no_echo();
      return treg == ir_reg ||
             (treg >= win_base && {1'b0, treg} <= {1'b0, win_base} + {1'b0, win_size});
    endfunction

    function void owe(logic [1:0] k, logic [7:0] b, logic l, logic [11:0] n);
      link_out_t e;
      e.kind = k;
      e.data = b;
      e.last = l;
      e.dlen = n;
      owed.push_back(e);
    endfunction

    function void complete();
      ph = PH_IDLE;
      bcnt = 0;
      n_done++;
      owe(KIND_DONE, '0, 1'b0, xlen);
    endfunction

    // returns 1 when the beat changes state or yields an output
    function bit accept_beat(logic [1:0] m, logic w, logic [11:0] len, logic [15:0] addr,
                             logic [7:0] d);
      int unsigned total;
      case (m)
        MODE_START: begin
          if (ph != PH_IDLE) return 1'b0;
          dir = w;
          xlen = len;
          treg = addr;
          fpos = 0;
          ph = PH_TX;
          return 1'b1;
        end
        MODE_LOAD: begin
          if (ph > PH_NAK_EAT || bcnt >= BUFFER_DEPTH_DEF) return 1'b0;
          wbuf[bcnt] = d;
          bcnt++;
          return 1'b1;
        end
        MODE_SLOT: begin
          if (ph != PH_TX) return 1'b0;
          total = hdr_bytes() + (dir ? int'(xlen) : 0);
          owe(KIND_TX, frame_at(fpos), 1'b0, '0);
          n_tx++;
          fpos++;
          if (fpos >= total) ph = PH_WAIT_ACK;
          return 1'b1;
        end
        default: begin
          case (ph)
            PH_WAIT_ACK: begin
              if (d == CODE_NAK) begin
                ph = PH_NAK_EAT;
                n_nak++;
              end else if (d == CODE_ACK) begin
                bcnt = hdr_bytes() - 1;
                ph = PH_SKIP_HDR;
              end else begin
                fpos = 0;
                ph = PH_TX;
                n_junk++;
              end
            end
            PH_NAK_EAT: begin
              fpos = 0;
              ph = PH_TX;
            end
            PH_SKIP_HDR: begin
              if (bcnt > 1) begin
                bcnt--;
              end else if (!dir) begin
                if (xlen == 0) begin
                  complete();
                end else begin
                  bcnt = xlen;
                  ph = PH_READ;
                end
              end else if (xlen == 0 || no_echo()) begin
                if (xlen != 0) n_exempt++;
                complete();
              end else begin
                bcnt = xlen;
                ph = PH_SKIP_ECHO;
              end
            end
            PH_READ: begin
              n_rd++;
              if (bcnt > 1) begin
                bcnt--;
                owe(KIND_READ, d, 1'b0, '0);
              end else begin
                ph = PH_IDLE;
                bcnt = 0;
                owe(KIND_READ, d, 1'b1, xlen);
              end
            end
            PH_SKIP_ECHO: begin
              if (bcnt > 1) bcnt--;
              else complete();
            end
            default: return 1'b0;
          endcase
          return 1'b1;
        end
      endcase
    endfunction

    function void check_output(logic [1:0] kind, logic [7:0] data, logic last,
                               logic [11:0] dlen);
      link_out_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output beat: kind %0d byte %02h last %0b length %0d",
                   kind, data, last, dlen);
        return;
      end
      want = owed.pop_front();
      if (kind !== want.kind || data !== want.data || last !== want.last ||
          dlen !== want.dlen) begin
        errors++;
        if (errors <= 10)
          $display("output mismatch: expected kind %0d byte %02h last %0b length %0d, got kind %0d byte %02h last %0b length %0d",
                   want.kind, want.data, want.last, want.dlen, kind, data, last, dlen);
      end
    endfunction
  endclass

endpackage

FILE: verif/tb.sv
// Randomized regression bench for the serial register access framer core.
`timescale 1ns / 1ps

module tb;
  import srafr_pkg::*;
  import framer_tracker_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_SLOT;
  logic        is_write = 1'b0;
  logic [11:0] length = '0;
  logic [15:0] reg_addr = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        is_last;
  logic [11:0] done_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_IR_DATA;
  logic [15:0] cfg_data = '0;

  framer_tracker trk;
  int unsigned   cycle_count = 0;
  int unsigned   beats_sent = 0;
  int unsigned   applied_items = 0;
  bit            tx_gaps_on = 1'b1;
  bit            rx_stall_on = 1'b1;
  int            hold_req = 0;
  int            stall_left = 0;

  serial_register_access_framer_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .is_write   (is_write),
    .length     (length),
    .reg_addr   (reg_addr),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .is_last    (is_last),
    .done_length(done_length),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("serial_register_access_framer_core regression: fail");
    $finish;
  end

  function automatic int gap_pick();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // output side: check the beat taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      trk.check_output(out_kind, out_byte, is_last, done_length);
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left == 0 && rx_stall_on) begin
      stall_left = gap_pick();
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(255) == 0) rx_stall_on = !rx_stall_on;
  end

  task automatic send_beat(input logic [1:0] m, input logic w, input logic [11:0] len,
                           input logic [15:0] addr, input logic [7:0] d);
    int g;
    g = tx_gaps_on ? gap_pick() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    is_write  <= w;
    length    <= len;
    reg_addr  <= addr;
    data_byte <= d;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (trk.accept_beat(m, w, len, addr, d)) applied_items++;
  endtask

  task automatic send_mode(input logic [1:0] m, input logic [7:0] d);
    send_beat(m, 1'($urandom), 12'($urandom), 16'($urandom), d);
  endtask

  // any mode with random fields; a command is only sent while busy, where it is dropped
  task automatic noise_beat();
    logic [1:0] m;
    m = 2'($urandom);
    if (m == MODE_START && trk.ph == PH_IDLE) m = MODE_SLOT;
    send_beat(m, 1'($urandom), 12'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Loads enough bytes that every frame data byte comes from a written entry.
  task automatic load_and_start(input logic w, input logic [11:0] len,
                                input logic [15:0] addr, input int noise_pct);
    int k;
    k = (!w || trk.bcnt >= len) ? 0 : int'(len) - int'(trk.bcnt);
    repeat (k) begin
      if ($urandom_range(99) < noise_pct) noise_beat();
      send_mode(MODE_LOAD, 8'($urandom));
    end
    send_beat(MODE_START, w, len, addr, 8'($urandom));
  endtask

  // first_reply < 0 picks the reply to the frame at random
  task automatic complete_transfer(input int first_reply, input int noise_pct);
    int         fails;
    bit         forced;
    logic [7:0] b;
    fails = 0;
    forced = (first_reply >= 0);
    while (trk.ph != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        noise_beat();
      end else if (trk.ph == PH_TX) begin
        send_mode(MODE_SLOT, 8'($urandom));
      end else if (trk.ph == PH_WAIT_ACK) begin
        if (forced) begin
          b = 8'(first_reply);
          forced = 1'b0;
        end else if (fails < 2 && $urandom_range(99) < 20) begin
          if ($urandom_range(1) == 1) begin
            b = CODE_NAK;
          end else begin
            do b = 8'($urandom); while (b == CODE_ACK || b == CODE_NAK);
          end
          fails++;
        end else begin
          b = CODE_ACK;
        end
        send_mode(MODE_RECV, b);
      end else begin
        send_mode(MODE_RECV, 8'($urandom));
      end
    end
  endtask

  task automatic run_transfer(input logic w, input logic [11:0] len, input logic [15:0] addr,
                              input int noise_pct);
    load_and_start(w, len, addr, noise_pct);
    complete_transfer(-1, noise_pct);
  endtask

  // drop valid and wait out everything in flight, including beats with no output
  task automatic settle();
    in_valid <= 1'b0;
    while (trk.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    trk.write_reg(idx, v);
  endtask

  task automatic program_regs(input logic [15:0] ir, input logic [15:0] base,
                              input logic [15:0] span);
    settle();
    cfg_write(CFG_IR_DATA, ir);
    cfg_write(CFG_EE_BASE, base);
    cfg_write(CFG_EE_SIZE, span);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [11:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 45) return 12'($urandom_range(4, 1));
    if (r < 75) return 12'($urandom_range(15, 5));
    if (r < 85) return r[0] ? 12'd15 : 12'd16;
    return 12'($urandom_range(48, 17));
  endfunction

  function automatic logic [15:0] pick_addr();
    int          r;
    int unsigned off;
    r = $urandom_range(99);
    off = $urandom_range(trk.win_size);
    if (r < 15) return trk.ir_reg;
    if (r < 35) return 16'(trk.win_base + off);
    if (r < 45) return 16'(trk.win_base + trk.win_size + 1);
    if (r < 50) return 16'(trk.win_base - 1);
    if (r < 58) return r[0] ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  initial begin
    int goal;
    int r;
    int failures;
    trk = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: stray slot and byte while idle, NAK path, command while busy,
    // restart on a non-ACK reply, write to an address without echo
    tx_gaps_on = 1'b0;
    send_mode(MODE_SLOT, 8'($urandom));
    send_mode(MODE_RECV, 8'($urandom));
    send_beat(MODE_START, 1'b0, 12'd0, 16'hFFFF, 8'($urandom));
    complete_transfer(CODE_NAK, 0);
    send_beat(MODE_START, 1'b0, 12'd2, 16'h8001, 8'($urandom));
    send_beat(MODE_START, 1'b1, 12'hFFF, 16'h0000, 8'hFF);
    complete_transfer(0, 0);
    run_transfer(1'b1, 12'd1, 16'h0000, 0);

    for (int s = 0; s < 6; s++) begin
      case (s)
        1: begin
          program_regs(16'h1234, 16'h8000, 16'h00FF);
          // read whose long function code carries a nonzero length high nibble
          run_transfer(1'b0, 12'h100, 16'($urandom), 0);
        end
        2: begin
          program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
          // receiver holds off while slots keep coming back to back
          hold_req = 150;
          tx_gaps_on = 1'b0;
          run_transfer(1'b1, 12'd30, 16'h2000, 0);
        end
        3: program_regs(16'($urandom), 16'hFF00, 16'h0200);
        4: program_regs(16'($urandom), 16'h0000, 16'hFFFF);
        5: program_regs(16'h0000, 16'h0000, 16'h0000);
        default: ;
      endcase
      goal = applied_items + RANDOM_ITEMS / 6;
      while (applied_items < goal) begin
        tx_gaps_on = ($urandom_range(3) != 0);
        r = $urandom_range(99);
        if (r < 78)
          run_transfer(1'($urandom), pick_len(), pick_addr(),
                       ($urandom_range(1) == 1) ? 0 : $urandom_range(8));
        else if (r < 88)
          repeat ($urandom_range(4, 1)) noise_beat();
        else if (r < 96)
          run_transfer(1'($urandom), pick_len(), pick_addr(), 35);
        else
          settle();
      end
    end

    settle();
    failures = trk.errors + trk.owed.size();
    if (trk.owed.size() != 0)
      $display("%0d expected output beats never arrived", trk.owed.size());
    $display("run covered %0d input beats (%0d with effect): %0d frame bytes, %0d read bytes, %0d completions",
             beats_sent, applied_items, trk.n_tx, trk.n_rd, trk.n_done);
    $display("replies: %0d NAKs, %0d restarts on other bytes, %0d writes without echo, 6 register settings",
             trk.n_nak, trk.n_junk, trk.n_exempt);
    if (failures == 0)
      $display("serial_register_access_framer_core regression: pass");
    else
      $display("serial_register_access_framer_core regression: fail");
    $finish;
  end

endmodule
